// File: sv/rlbd_pkg.sv
// shared constants, types and helpers of the bit-packed run-length decoder
package rlbd_pkg;

	// default widths of the coded numbers and of one input word
	localparam int VALUE_BITS_DEF = 10;
	localparam int WORD_BITS_DEF  = 32;

	// fixed widths of the result fields
	localparam int SAMPLE_W = 10;
	localparam int REPEAT_W = 11;
	localparam int COUNT_W  = 16;

	// run results emitted per word at most
	localparam int MAX_RUNS = 16;

	// depth of the queues on either side of the parser
	localparam int QUEUE_DEPTH = 2;

	// per-word flags that travel with the data word
	typedef struct packed {
		logic               first;
		logic               last;
		logic [COUNT_W-1:0] expected;
	} word_ctrl_t;

	// one result beat
	typedef struct packed {
		logic                is_status;
		logic [SAMPLE_W-1:0] sample_value;
		logic [REPEAT_W-1:0] repeat_count;
		logic                error_flag;
		logic [COUNT_W-1:0]  words_used;
		logic                end_of_event;
	} result_t;

	// saturating increment of a 16-bit counter
	function automatic logic [COUNT_W-1:0] sat_inc16(input logic [COUNT_W-1:0] v);
		logic [COUNT_W-1:0] r;
		if (v == {COUNT_W{1'b1}}) begin
			r = v;
		end else begin
			r = v + COUNT_W'(1);
		end
		return r;
	endfunction

endpackage

// File: sv/rlbd_fifo.sv
// small first-word-fall-through queue built from registers
module rlbd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rlbd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_ok;
	logic             rd_ok;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_ok   = wr_en && !full;
	assign rd_ok   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_ok) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_ok && !rd_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_ok && !wr_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// fill count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count above depth");

	// writers look at full before writing
	a_no_wr_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("queue written while full");

endmodule

// File: sv/rlbd_front.sv
// front end: takes input beats, drops words outside an event, queues the rest
module rlbd_front #(
	parameter int WORD_BITS = rlbd_pkg::WORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [WORD_BITS-1:0]               data_word,
	input  logic                               first_word,
	input  logic                               last_word,
	input  logic [rlbd_pkg::COUNT_W-1:0]       expected_samples,
	output logic                               q_valid,
	input  logic                               q_pop,
	output logic [WORD_BITS-1:0]               q_data,
	output rlbd_pkg::word_ctrl_t               q_ctrl
);

	localparam int CTRL_W = $bits(rlbd_pkg::word_ctrl_t);
	localparam int ENT_W  = WORD_BITS + CTRL_W;

	logic                 open_q;
	logic                 accept;
	logic                 in_event;
	logic                 q_push;
	logic                 q_empty;
	rlbd_pkg::word_ctrl_t in_ctrl;
	logic [ENT_W-1:0]     q_entry;

	assign accept   = push && !full;
	assign in_event = first_word || open_q;
	assign q_push   = accept && in_event;

	assign in_ctrl.first    = first_word;
	assign in_ctrl.last     = last_word;
	assign in_ctrl.expected = expected_samples;

	// event tracking: a first word opens, a last word closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (accept) begin
			open_q <= in_event && !last_word;
		end
	end

	rlbd_fifo #(
		.WIDTH (ENT_W),
		.DEPTH (rlbd_pkg::QUEUE_DEPTH)
	) u_word_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data ({data_word, in_ctrl}),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_entry),
		.empty   (q_empty)
	);

	assign q_valid = !q_empty;
	assign q_data  = q_entry[ENT_W-1:CTRL_W];
	assign q_ctrl  = rlbd_pkg::word_ctrl_t'(q_entry[CTRL_W-1:0]);

endmodule

// File: sv/rlbd_back.sv
// back end: walks the bits of one queued word and emits run and status beats
module rlbd_back #(
	parameter int VALUE_BITS = rlbd_pkg::VALUE_BITS_DEF,
	parameter int WORD_BITS  = rlbd_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_pop,
	input  logic [WORD_BITS-1:0] in_data,
	input  rlbd_pkg::word_ctrl_t in_ctrl,
	output logic                 out_push,
	input  logic                 out_full,
	output rlbd_pkg::result_t    out_item
);

	localparam int CW    = rlbd_pkg::COUNT_W;
	localparam int SUM_W = CW + 1;
	localparam int BL_W  = $clog2(VALUE_BITS + 1);
	localparam int BI_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int RN_W  = $clog2(rlbd_pkg::MAX_RUNS + 1);
	localparam logic [BI_W-1:0] LAST_BIT = BI_W'(WORD_BITS - 1);
	localparam logic [BL_W-1:0] BL_FULL  = BL_W'(VALUE_BITS);
	localparam logic [RN_W-1:0] RUN_CAP  = RN_W'(rlbd_pkg::MAX_RUNS);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BITS = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// parse phases
	localparam logic [1:0] PH_VAL_IND = 2'd0;
	localparam logic [1:0] PH_VAL     = 2'd1;
	localparam logic [1:0] PH_RUN_IND = 2'd2;
	localparam logic [1:0] PH_RUN     = 2'd3;

	logic [1:0]            state_q, state_d;
	logic [1:0]            phase_q, phase_d;
	logic [BL_W-1:0]       bits_left_q, bits_left_d;
	logic [VALUE_BITS-1:0] val_acc_q, val_acc_d;
	logic [VALUE_BITS-1:0] run_acc_q, run_acc_d;
	logic [VALUE_BITS-1:0] held_q, held_d;
	logic [SUM_W-1:0]      samples_q, samples_d;
	logic [CW-1:0]         target_q, target_d;
	logic [CW-1:0]         word_idx_q, word_idx_d;
	logic [CW-1:0]         stop_q, stop_d;
	logic                  partial_q, partial_d;
	logic                  finished_q, finished_d;
	logic [BI_W-1:0]       bit_idx_q, bit_idx_d;
	logic [RN_W-1:0]       runs_q, runs_d;
	logic [WORD_BITS-1:0]  data_q, data_d;
	logic                  last_q, last_d;

	logic                  out_ready;
	logic                  load_first;
	logic                  cur_bit;
	logic [VALUE_BITS-1:0] val_shift;
	logic [VALUE_BITS-1:0] run_shift;
	logic                  pair;
	logic [SUM_W-1:0]      rc;
	logic [SUM_W-1:0]      sum_new;
	logic                  err;
	logic [CW-1:0]         used;

	assign out_ready  = !out_full;
	assign load_first = (state_q == ST_IDLE) && in_valid && in_ctrl.first;
	assign cur_bit    = data_q[bit_idx_q];

	// coded numbers arrive lsb first: shift in from the top
	assign val_shift = (val_acc_q >> 1) | (VALUE_BITS'(cur_bit) << (VALUE_BITS - 1));
	assign run_shift = (run_acc_q >> 1) | (VALUE_BITS'(cur_bit) << (VALUE_BITS - 1));

	// closing status of the event
	always_comb begin
		if (finished_q) begin
			err  = (samples_q != SUM_W'(target_q)) || (stop_q != word_idx_q);
			used = partial_q ? rlbd_pkg::sat_inc16(stop_q) : stop_q;
		end else begin
			err  = 1'b1;
			used = rlbd_pkg::sat_inc16(word_idx_q);
		end
	end

	// sequencer and bit parser
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		bits_left_d = bits_left_q;
		val_acc_d   = val_acc_q;
		run_acc_d   = run_acc_q;
		held_d      = held_q;
		samples_d   = samples_q;
		target_d    = target_q;
		word_idx_d  = word_idx_q;
		stop_d      = stop_q;
		partial_d   = partial_q;
		finished_d  = finished_q;
		bit_idx_d   = bit_idx_q;
		runs_d      = runs_q;
		data_d      = data_q;
		last_d      = last_q;
		in_pop      = 1'b0;
		out_push    = 1'b0;
		out_item    = '0;
		pair        = 1'b0;
		rc          = '0;
		sum_new     = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					in_pop    = 1'b1;
					data_d    = in_data;
					last_d    = in_ctrl.last;
					bit_idx_d = '0;
					runs_d    = '0;
					state_d   = ST_BITS;
					if (in_ctrl.first) begin
						phase_d     = PH_VAL_IND;
						bits_left_d = '0;
						val_acc_d   = '0;
						run_acc_d   = '0;
						held_d      = '0;
						samples_d   = '0;
						word_idx_d  = '0;
						target_d    = in_ctrl.expected;
						finished_d  = (in_ctrl.expected == '0);
						stop_d      = '0;
						partial_d   = 1'b0;
					end
				end
			end
			ST_BITS: begin
				if (finished_q) begin
					state_d = ST_DONE;
				end else if (out_ready) begin
					unique case (phase_q)
						PH_VAL_IND: begin
							if (cur_bit) begin
								phase_d     = PH_VAL;
								bits_left_d = BL_FULL;
								val_acc_d   = '0;
							end else begin
								held_d  = '0;
								phase_d = PH_RUN_IND;
							end
						end
						PH_VAL: begin
							val_acc_d   = val_shift;
							bits_left_d = bits_left_q - BL_W'(1);
							if (bits_left_q == BL_W'(1)) begin
								held_d  = val_shift;
								phase_d = PH_RUN_IND;
							end
						end
						PH_RUN_IND: begin
							if (cur_bit) begin
								phase_d     = PH_RUN;
								bits_left_d = BL_FULL;
								run_acc_d   = '0;
							end else begin
								run_acc_d = '0;
								pair      = 1'b1;
								rc        = SUM_W'(1);
							end
						end
						default: begin
							run_acc_d   = run_shift;
							bits_left_d = bits_left_q - BL_W'(1);
							if (bits_left_q == BL_W'(1)) begin
								pair = 1'b1;
								rc   = SUM_W'(run_shift) + SUM_W'(1);
							end
						end
					endcase

					// a finished pair gives a run beat, up to MAX_RUNS per word, and counts toward the total
					if (pair) begin
						phase_d = PH_VAL_IND;
						if (runs_q < RUN_CAP) begin
							out_push              = 1'b1;
							out_item.sample_value = rlbd_pkg::SAMPLE_W'(held_d);
							out_item.repeat_count = rlbd_pkg::REPEAT_W'(rc);
							runs_d                = runs_q + RN_W'(1);
						end
						sum_new   = samples_q + rc;
						samples_d = sum_new;
						if (sum_new >= SUM_W'(target_q)) begin
							finished_d = 1'b1;
							if (bit_idx_q == LAST_BIT) begin
								stop_d    = rlbd_pkg::sat_inc16(word_idx_q);
								partial_d = 1'b0;
							end else begin
								stop_d    = word_idx_q;
								partial_d = 1'b1;
							end
						end
					end

					if (bit_idx_q == LAST_BIT) begin
						state_d = ST_DONE;
					end else begin
						bit_idx_d = bit_idx_q + BI_W'(1);
					end
				end
			end
			default: begin
				// close the word, with a status beat on the last one
				if (!last_q) begin
					word_idx_d = rlbd_pkg::sat_inc16(word_idx_q);
					state_d    = ST_IDLE;
				end else if (out_ready) begin
					out_push              = 1'b1;
					out_item.is_status    = 1'b1;
					out_item.error_flag   = err;
					out_item.words_used   = used;
					out_item.end_of_event = 1'b1;
					word_idx_d            = rlbd_pkg::sat_inc16(word_idx_q);
					state_d               = ST_IDLE;
				end
			end
		endcase
	end

	// word buffer, no reset needed
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	// parser and event state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_VAL_IND;
			bits_left_q <= '0;
			val_acc_q   <= '0;
			run_acc_q   <= '0;
			held_q      <= '0;
			samples_q   <= '0;
			target_q    <= '0;
			word_idx_q  <= '0;
			stop_q      <= '0;
			partial_q   <= 1'b0;
			finished_q  <= 1'b0;
			bit_idx_q   <= '0;
			runs_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			bits_left_q <= bits_left_d;
			val_acc_q   <= val_acc_d;
			run_acc_q   <= run_acc_d;
			held_q      <= held_d;
			samples_q   <= samples_d;
			target_q    <= target_d;
			word_idx_q  <= word_idx_d;
			stop_q      <= stop_d;
			partial_q   <= partial_d;
			finished_q  <= finished_d;
			bit_idx_q   <= bit_idx_d;
			runs_q      <= runs_d;
			last_q      <= last_d;
		end
	end

	// result beats only go out when the result queue has room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> out_ready)
		else $error("result beat pushed into a full queue");

	// a status beat only closes a last word
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && out_item.is_status) |-> ((state_q == ST_DONE) && last_q))
		else $error("status beat outside the close of a last word");

	// once stopped, decoding stays stopped until a new event starts
	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(finished_q && !load_first) |=> finished_q)
		else $error("decoding restarted without a first word");

endmodule

// File: sv/bitstream_run_length_decoder_unit.sv
// top level of the bit-packed run-length decoder: front, parser and result queue
//
//   channel  | handshake         | beat
//   ---------+-------------------+------------------------------------------------
//   input    | push / full       | data_word, first_word, last_word, expected_samples
//   result   | pop / empty       | is_status, sample_value, repeat_count,
//            |                   | error_flag, words_used, end_of_event
//
// each queued word goes through load, the serial bit parser at one bit per cycle
// while the result queue has room, and close; once the expected total is reached
// the remaining bits are skipped.
// a word outside an event is taken and dropped by the front end at once.
// a full result queue stalls the parser; the input queue takes words until full.
// reset clears both queues, closes any open event and zeroes the parser state.
module bitstream_run_length_decoder_unit #(
	parameter int VALUE_BITS = rlbd_pkg::VALUE_BITS_DEF,
	parameter int WORD_BITS  = rlbd_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [WORD_BITS-1:0]          data_word,
	input  logic                          first_word,
	input  logic                          last_word,
	input  logic [rlbd_pkg::COUNT_W-1:0]  expected_samples,
	output logic                          empty,
	input  logic                          pop,
	output logic                          is_status,
	output logic [rlbd_pkg::SAMPLE_W-1:0] sample_value,
	output logic [rlbd_pkg::REPEAT_W-1:0] repeat_count,
	output logic                          error_flag,
	output logic [rlbd_pkg::COUNT_W-1:0]  words_used,
	output logic                          end_of_event
);

	localparam int RES_W = $bits(rlbd_pkg::result_t);

	logic                 q_valid;
	logic                 q_pop;
	logic [WORD_BITS-1:0] q_data;
	rlbd_pkg::word_ctrl_t q_ctrl;
	logic                 res_push;
	logic                 res_full;
	rlbd_pkg::result_t    res_item;
	logic [RES_W-1:0]     head_bits;
	rlbd_pkg::result_t    head;

	rlbd_front #(
		.WORD_BITS (WORD_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.data_word        (data_word),
		.first_word       (first_word),
		.last_word        (last_word),
		.expected_samples (expected_samples),
		.q_valid          (q_valid),
		.q_pop            (q_pop),
		.q_data           (q_data),
		.q_ctrl           (q_ctrl)
	);

	rlbd_back #(
		.VALUE_BITS (VALUE_BITS),
		.WORD_BITS  (WORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_pop   (q_pop),
		.in_data  (q_data),
		.in_ctrl  (q_ctrl),
		.out_push (res_push),
		.out_full (res_full),
		.out_item (res_item)
	);

	// result queue decouples the parser from the consumer
	rlbd_fifo #(
		.WIDTH (RES_W),
		.DEPTH (rlbd_pkg::QUEUE_DEPTH)
	) u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_item),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (head_bits),
		.empty   (empty)
	);

	// oldest result onto the ports
	assign head         = rlbd_pkg::result_t'(head_bits);
	assign is_status    = head.is_status;
	assign sample_value = head.sample_value;
	assign repeat_count = head.repeat_count;
	assign error_flag   = head.error_flag;
	assign words_used   = head.words_used;
	assign end_of_event = head.end_of_event;

endmodule

// File: sim/testbench.sv
// self-checking testbench for the bit-packed run-length decoder unit
module testbench;

	localparam int VB          = rlbd_pkg::VALUE_BITS_DEF;
	localparam int WB          = rlbd_pkg::WORD_BITS_DEF;
	localparam int COUNT_W     = rlbd_pkg::COUNT_W;
	localparam int SAMPLE_W    = rlbd_pkg::SAMPLE_W;
	localparam int REPEAT_W    = rlbd_pkg::REPEAT_W;
	localparam int MAX_RUNS    = rlbd_pkg::MAX_RUNS;
	localparam int LONG_HOLD   = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 4 * (WB + 2);
	localparam int RAND_WORDS  = 75;

	typedef rlbd_pkg::result_t result_t;

	typedef enum logic [1:0] {
		PH_VAL_IND, PH_VAL_BITS, PH_RUN_IND, PH_RUN_BITS
	} parse_phase_t;
	typedef enum logic [1:0] {BY_DECODER, NO_BEAT, ONE_BEAT} check_t;

	typedef struct {
		logic [WB-1:0]      data;
		logic               first;
		logic               last;
		logic [COUNT_W-1:0] count;
	} word_t;

	typedef struct {
		word_t   w;
		check_t  how;
		result_t beat;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	logic [WB-1:0]       data_word = '0;
	logic                first_word = 1'b0;
	logic                last_word = 1'b0;
	logic [COUNT_W-1:0]  expected_samples = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic                is_status;
	logic [SAMPLE_W-1:0] sample_value;
	logic [REPEAT_W-1:0] repeat_count;
	logic                error_flag;
	logic [COUNT_W-1:0]  words_used;
	logic                end_of_event;

	// decoder state mirrored by the predictor
	parse_phase_t       phase;
	int unsigned        bits_remaining;
	logic [VB-1:0]      value_acc, run_acc, held;
	logic [16:0]        total;
	logic [COUNT_W-1:0] target, word_idx, stop_pos;
	bit                 done, stop_mid, in_event;

	result_t     fresh_beats[$];
	result_t     pending_beats[$];
	row_t        directed_rows[$];
	word_t       event_words[$];
	logic [255:0] bitbuf;
	int unsigned bitpos;

	int  mismatches = 0;
	int  words_sent = 0;
	int  runs_seen = 0;
	int  status_seen = 0;
	int  hold_cycles = 0;
	bit  long_hold_req = 0;
	bit  tx_idle_on = 0;
	bit  rx_idle_on = 0;

	bitstream_run_length_decoder_unit #(
		.VALUE_BITS(VB),
		.WORD_BITS(WB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_word(data_word),
		.first_word(first_word),
		.last_word(last_word),
		.expected_samples(expected_samples),
		.empty(empty),
		.pop(pop),
		.is_status(is_status),
		.sample_value(sample_value),
		.repeat_count(repeat_count),
		.error_flag(error_flag),
		.words_used(words_used),
		.end_of_event(end_of_event)
	);

	always #6 clk = ~clk;

	function automatic logic [COUNT_W-1:0] sat16(input logic [COUNT_W-1:0] v);
		return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
	endfunction

	function automatic result_t run_beat(input logic [SAMPLE_W-1:0] v,
			input logic [REPEAT_W-1:0] rc);
		return {1'b0, v, rc, 1'b0, {COUNT_W{1'b0}}, 1'b0};
	endfunction

	function automatic result_t status_beat(input logic err, input logic [COUNT_W-1:0] used);
		return {1'b1, {SAMPLE_W{1'b0}}, {REPEAT_W{1'b0}}, err, used, 1'b1};
	endfunction

	function automatic logic [VB-1:0] pick_number();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return VB'($urandom_range(0, 7));
			2: return {VB{1'b1}};
			default: return VB'($urandom());
		endcase
	endfunction

	// bit-serial decode of one word; beats it causes land in fresh_beats
	task automatic decode_word(input word_t w);
		int unsigned b;
		logic bitv;
		bit pair;
		logic [REPEAT_W-1:0] rc;
		logic err;
		logic [COUNT_W-1:0] used;
		fresh_beats.delete();
		if (w.first) begin
			in_event = 1;
			phase = PH_VAL_IND;
			bits_remaining = 0;
			value_acc = '0;
			run_acc = '0;
			held = '0;
			total = '0;
			word_idx = '0;
			target = w.count;
			done = (w.count == 0);
			stop_pos = '0;
			stop_mid = 0;
		end
		if (!in_event) return;
		for (b = 0; b < WB && !done; b++) begin
			bitv = w.data[b];
			pair = 0;
			case (phase)
				PH_VAL_IND: begin
					if (bitv) begin
						phase = PH_VAL_BITS;
						bits_remaining = VB;
						value_acc = '0;
					end else begin
						held = '0;
						phase = PH_RUN_IND;
					end
				end
				PH_VAL_BITS: begin
					value_acc[VB - bits_remaining] = bitv;
					bits_remaining--;
					if (bits_remaining == 0) begin
						held = value_acc;
						phase = PH_RUN_IND;
					end
				end
				PH_RUN_IND: begin
					if (bitv) begin
						phase = PH_RUN_BITS;
						bits_remaining = VB;
						run_acc = '0;
					end else begin
						run_acc = '0;
						pair = 1;
					end
				end
				default: begin
					run_acc[VB - bits_remaining] = bitv;
					bits_remaining--;
					if (bits_remaining == 0) pair = 1;
				end
			endcase
			// completed pair: emit a run and check the stop condition
			if (pair) begin
				rc = REPEAT_W'(run_acc) + REPEAT_W'(1);
				phase = PH_VAL_IND;
				if (fresh_beats.size() < MAX_RUNS)
					fresh_beats.push_back(run_beat(SAMPLE_W'(held), rc));
				total += rc;
				if (total >= target) begin
					done = 1;
					if (b + 1 == WB) begin
						stop_pos = sat16(word_idx);
						stop_mid = 0;
					end else begin
						stop_pos = word_idx;
						stop_mid = 1;
					end
				end
			end
		end
		// closing status of the event
		if (w.last) begin
			if (done) begin
				err = (total != {1'b0, target}) || (stop_pos != word_idx);
				used = stop_mid ? sat16(stop_pos) : stop_pos;
			end else begin
				err = 1'b1;
				used = sat16(word_idx);
			end
			fresh_beats.push_back(status_beat(err, used));
			in_event = 0;
		end
		word_idx = sat16(word_idx);
	endtask

	// drive one word until taken, then record what it should produce
	task automatic offer_word(input word_t w, input check_t how, input result_t beat);
		int unsigned gap;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			gap = $urandom_range(1, 14);
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_word <= w.data;
		first_word <= w.first;
		last_word <= w.last;
		expected_samples <= w.count;
		do @(posedge clk); while (full !== 1'b0);
		words_sent++;
		decode_word(w);
		case (how)
			BY_DECODER: foreach (fresh_beats[i]) pending_beats.push_back(fresh_beats[i]);
			ONE_BEAT: pending_beats.push_back(beat);
			default: ;
		endcase
	endtask

	task automatic add_row(input logic [WB-1:0] data, input logic first, input logic last,
			input logic [COUNT_W-1:0] count, input check_t how, input result_t beat);
		row_t r;
		r.w.data = data;
		r.w.first = first;
		r.w.last = last;
		r.w.count = count;
		r.how = how;
		r.beat = beat;
		directed_rows.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_beats.size() != 0) @(posedge clk);
	endtask

	task automatic put_number(input logic [VB-1:0] v);
		if (v == 0 && $urandom_range(0, 1) == 0) begin
			bitbuf[bitpos] = 1'b0;
			bitpos++;
		end else begin
			bitbuf[bitpos] = 1'b1;
			bitpos++;
			for (int i = 0; i < VB; i++) begin
				bitbuf[bitpos] = v[i];
				bitpos++;
			end
		end
	endtask

	// well-formed event with random pairs, sometimes broken on purpose
	task automatic make_event();
		int unsigned pairs, run_total, prev_total, goal, nwords, flavor, k;
		logic [VB-1:0] v, r;
		word_t w;
		for (k = 0; k < 8; k++) bitbuf[32*k +: 32] = $urandom();
		bitpos = 0;
		run_total = 0;
		prev_total = 0;
		r = '0;
		pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 5);
		for (k = 0; k < pairs; k++) begin
			v = pick_number();
			r = pick_number();
			put_number(v);
			put_number(r);
			prev_total = run_total;
			run_total += r + 1;
		end
		nwords = (bitpos + 31) / 32;
		goal = run_total;
		flavor = $urandom_range(0, 9);
		if (flavor == 6) begin
			// last run may pass the expected total
			goal = prev_total + $urandom_range(1, r + 1);
		end else if (flavor == 7) begin
			nwords++;
		end else if (flavor == 8) begin
			// words run out before the total is reached
			if (bitpos / 32 > 0) nwords = bitpos / 32;
			else goal = run_total + $urandom_range(1, 50);
		end else if (flavor == 9) begin
			goal = $urandom_range(0, 65535);
		end
		event_words.delete();
		for (k = 0; k < nwords; k++) begin
			w.data = bitbuf[32*k +: 32];
			w.first = (k == 0);
			w.last = (k == nwords - 1) && ($urandom_range(0, 11) != 0);
			w.count = (k == 0) ? COUNT_W'(goal) : COUNT_W'($urandom());
			event_words.push_back(w);
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_beat();
		result_t got, want;
		got = {is_status, sample_value, repeat_count, error_flag, words_used, end_of_event};
		if (got.is_status) status_seen++;
		else runs_seen++;
		if (pending_beats.size() == 0) begin
			$display("%0t: beat with nothing pending: status %0b value %0d count %0d",
				$time, got.is_status, got.sample_value, got.repeat_count);
			mismatches++;
		end else begin
			want = pending_beats.pop_front();
			compare_field("is_status", want.is_status, got.is_status);
			compare_field("sample_value", want.sample_value, got.sample_value);
			compare_field("repeat_count", want.repeat_count, got.repeat_count);
			compare_field("error_flag", want.error_flag, got.error_flag);
			compare_field("words_used", want.words_used, got.words_used);
			compare_field("end_of_event", want.end_of_event, got.end_of_event);
		end
	endtask

	// result side: check each taken beat, then pick pop for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && empty === 1'b0) check_beat();
			if (long_hold_req) begin
				long_hold_req = 0;
				hold_cycles = LONG_HOLD;
			end
			if (hold_cycles > 0) begin
				pop <= 1'b0;
				hold_cycles--;
			end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				hold_cycles = $urandom_range(0, 13);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no beat on either side
	initial begin
		int idle_cnt;
		idle_cnt = 0;
		while (idle_cnt < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && full === 1'b0) || (pop && empty === 1'b0)) idle_cnt = 0;
			else idle_cnt++;
		end
		$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int rand_words, noise_words;
		word_t w;
		in_event = 0;
		done = 0;
		rand_words = 0;
		noise_words = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		add_row(32'hFFFF_FFFF, 1'b0, 1'b1, 16'hFFFF, NO_BEAT, '0);
		add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 16'h0000, ONE_BEAT, status_beat(1'b0, 16'd0));
		add_row(32'h0000_0000, 1'b0, 1'b0, 16'h0000, NO_BEAT, '0);
		add_row(32'h0000_0000, 1'b1, 1'b1, 16'd1, BY_DECODER, '0);
		add_row(32'h003F_FFFF, 1'b1, 1'b1, 16'd1024, BY_DECODER, '0);
		add_row(32'h0000_07FF, 1'b1, 1'b1, 16'd1, BY_DECODER, '0);
		add_row(32'h0000_0000, 1'b1, 1'b1, 16'd16, BY_DECODER, '0);
		add_row(32'hFFFF_FFFF, 1'b1, 1'b0, 16'hFFFF, BY_DECODER, '0);
		add_row(32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, BY_DECODER, '0);
		add_row(32'h0000_0000, 1'b0, 1'b1, 16'h5A5A, BY_DECODER, '0);
		add_row(32'h003F_FFFF, 1'b1, 1'b1, 16'd2, BY_DECODER, '0);
		add_row(32'h0000_0000, 1'b1, 1'b0, 16'd1, BY_DECODER, '0);
		add_row(32'hA5A5_A5A5, 1'b0, 1'b0, 16'd7, BY_DECODER, '0);
		add_row(32'h5A5A_5A5A, 1'b0, 1'b1, 16'd9, BY_DECODER, '0);
		add_row(32'hFFFF_FFFF, 1'b1, 1'b0, 16'd100, BY_DECODER, '0);
		add_row(32'h0000_0000, 1'b1, 1'b1, 16'd3, BY_DECODER, '0);
		add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 16'd2000, BY_DECODER, '0);
		add_row(32'h1234_5678, 1'b1, 1'b0, 16'h0000, BY_DECODER, '0);
		add_row(32'h8765_4321, 1'b0, 1'b1, 16'hFFFF, BY_DECODER, '0);
		add_row(32'hFFFF_FFFF, 1'b0, 1'b1, 16'h0000, NO_BEAT, '0);
		tx_idle_on = 1;
		rx_idle_on = 1;
		foreach (directed_rows[i])
			offer_word(directed_rows[i].w, directed_rows[i].how, directed_rows[i].beat);
		push <= 1'b0;
		wait_drained();

		// back-pressure: result side holds off while runs of zeros keep coming
		tx_idle_on = 0;
		long_hold_req = 1;
		for (int e = 0; e < 4; e++) begin
			for (int k = 0; k < 3; k++) begin
				w.data = '0;
				w.first = (k == 0);
				w.last = (k == 2);
				w.count = 16'd48;
				offer_word(w, BY_DECODER, '0);
			end
		end
		push <= 1'b0;
		wait_drained();

		// random events, idling off near the end
		tx_idle_on = 1;
		while (rand_words < RAND_WORDS) begin
			if (rand_words > RAND_WORDS - 20) begin
				tx_idle_on = 0;
				rx_idle_on = 0;
			end
			if (!in_event && $urandom_range(0, 9) == 0) begin
				w.data = $urandom();
				w.first = 1'b0;
				w.last = $urandom_range(0, 1);
				w.count = COUNT_W'($urandom());
				offer_word(w, BY_DECODER, '0);
				noise_words++;
			end
			make_event();
			foreach (event_words[i]) begin
				offer_word(event_words[i], BY_DECODER, '0);
				rand_words++;
			end
		end
		push <= 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d words: directed table, back-pressure, %0d in random events",
			words_sent, rand_words);
		$display("checked %0d run beats and %0d status beats, %0d stray words outside events",
			runs_seen, status_seen, noise_words);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
sv/rlbd_pkg.sv
sv/rlbd_fifo.sv
sv/rlbd_front.sv
sv/rlbd_back.sv
sv/bitstream_run_length_decoder_unit.sv
sim/testbench.sv
